// ----- hw/rtl/stn_pkg.sv -----
// ----------------------------------------------------------------------------
// stn_pkg: shared types and constants of the source text tokenizer
// Token codes, queue record layout and the keyword tables.
// ----------------------------------------------------------------------------
`default_nettype none

package stn_pkg;

	// keyword and number limits
	localparam int KW_COUNT    = 9;
	localparam int MAX_SIG     = 19;
	localparam int QUEUE_DEPTH = 4;
	localparam int REC_LEN_W   = 8;

	// token kinds
	localparam logic [5:0] TK_ASSIGN = 6'd15;
	localparam logic [5:0] TK_IDENT  = 6'd21;
	localparam logic [5:0] TK_KEY0   = 6'd22;
	localparam logic [5:0] TK_INT    = 6'd31;
	localparam logic [5:0] TK_REAL   = 6'd32;
	localparam logic [5:0] TK_FAIL   = 6'd33;
	localparam logic [5:0] TK_END    = 6'd34;

	// queue record classes
	localparam logic [1:0] REC_DIRECT = 2'd0;
	localparam logic [1:0] REC_IDENT  = 2'd1;
	localparam logic [1:0] REC_INT    = 2'd2;
	localparam logic [1:0] REC_REAL   = 2'd3;

	// one pending token, not yet resolved
	typedef struct packed {
		logic [1:0]          cls;
		logic [5:0]          kind;
		logic [63:0]         acc;
		logic [4:0]          frac;
		logic [REC_LEN_W-1:0] ilen;
		logic [KW_COUNT-1:0] cand;
		logic                ovf;
		logic                last;
	} tok_rec_t;

	// front to queue write request
	typedef struct packed {
		logic     push0;
		logic     push1;
		tok_rec_t rec0;
		tok_rec_t rec1;
	} q_push_t;

	// keyword spelling, element 0 is the first character
	function automatic logic [4:0][7:0] kw_text(input logic [3:0] k);
		case (k)
			4'd0: return {8'h00, 8'h00, 8'h00, "n", "i"};
			4'd1: return {8'h00, 8'h00, "t", "u", "o"};
			4'd2: return {"t", "n", "e", "v", "e"};
			4'd3: return {8'h00, "e", "d", "o", "n"};
			4'd4: return {"y", "r", "e", "u", "q"};
			4'd5: return {"t", "a", "o", "l", "f"};
			4'd6: return {8'h00, "l", "o", "o", "b"};
			4'd7: return {8'h00, "e", "u", "r", "t"};
			4'd8: return {"e", "s", "l", "a", "f"};
			default: return '0;
		endcase
	endfunction

	// keyword length
	function automatic logic [2:0] kw_len(input logic [3:0] k);
		case (k)
			4'd0: return 3'd2;
			4'd1: return 3'd3;
			4'd2: return 3'd5;
			4'd3: return 3'd4;
			4'd4: return 3'd5;
			4'd5: return 3'd5;
			4'd6: return 3'd4;
			4'd7: return 3'd4;
			4'd8: return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stn_char_if.sv -----
// ----------------------------------------------------------------------------
// stn_char_if: character input channel
// Valid/ready channel carrying one source byte or an end-of-input mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface stn_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/stn_tok_if.sv -----
// ----------------------------------------------------------------------------
// stn_tok_if: token output channel
// Valid/ready channel carrying one token and its value fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface stn_tok_if #(
	parameter int LEN_W = 7
);
	logic             valid;
	logic             ready;
	logic [5:0]       token_kind;
	logic [30:0]      int_value;
	logic [63:0]      real_mantissa;
	logic [4:0]       fraction_digits;
	logic [LEN_W-1:0] name_length;
	logic             last_of_run;

	modport source (output valid, output token_kind, output int_value, output real_mantissa,
		output fraction_digits, output name_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input int_value, input real_mantissa,
		input fraction_digits, input name_length, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/source_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: byte-serial lexical analyzer
// char_in takes one source byte per request, or an end-of-input request
// that flushes the pending token and then gives the end token.
// token_out gives one token per request; last_of_run marks the final
// token caused by an input request (a byte can give zero, one or two).
// Throughput: one byte per cycle while the queue has room; a byte that
// gives two tokens hands them out one at a time by the single output register.
// A token is written into the queue when the byte that completes it is
// accepted, then resolved at the queue head and held in the output register.
// A four-entry record queue parts the scanner from the output stage;
// char_in.ready drops while fewer than two entries are free, so a stalled
// receiver holds the front after at most a few bytes, nothing is lost.
// Reset clears the scan state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top #(
	parameter int MAX_NAME_LENGTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stn_char_if.sink   char_in,
	stn_tok_if.source  token_out
);

	stn_pkg::q_push_t  push;
	stn_pkg::tok_rec_t head;
	logic              room;
	logic              head_valid;
	logic              pop;

	// scanner front end
	stn_front #(
		.MAX_NAME_LENGTH(MAX_NAME_LENGTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.room    (room),
		.push    (push)
	);

	// record queue
	stn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (head_valid),
		.head       (head)
	);

	// resolver and output register
	stn_back #(
		.MAX_NAME_LENGTH(MAX_NAME_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.token_out  (token_out)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/stn_front.sv -----
// ----------------------------------------------------------------------------
// stn_front: scanner front end
// Takes one byte per cycle while there is room, tracks the pending token
// and writes up to two unresolved token records per byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_front #(
	parameter int MAX_NAME_LENGTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	stn_char_if.sink             char_in,
	input  wire logic            room,
	output stn_pkg::q_push_t     push
);

	localparam int LEN_W = $clog2(MAX_NAME_LENGTH + 1);
	localparam logic [stn_pkg::KW_COUNT-1:0] ALL_KEYS = '1;

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_CMP   = 3'd1;
	localparam logic [2:0] MODE_IDENT = 3'd2;
	localparam logic [2:0] MODE_INT   = 3'd3;
	localparam logic [2:0] MODE_FRAC  = 3'd4;

	// scan state
	logic [2:0]                    mode_q;
	logic [63:0]                   acc_q;
	logic [4:0]                    dcnt_q;
	logic [4:0]                    fcnt_q;
	logic [LEN_W-1:0]              ilen_q;
	logic [stn_pkg::KW_COUNT-1:0]  cand_q;
	logic [1:0]                    pcmp_q;
	logic                          ovf_q;

	logic [2:0]                    mode_d;
	logic [63:0]                   acc_d;
	logic [4:0]                    dcnt_d;
	logic [4:0]                    fcnt_d;
	logic [LEN_W-1:0]              ilen_d;
	logic [stn_pkg::KW_COUNT-1:0]  cand_d;
	logic [1:0]                    pcmp_d;
	logic                          ovf_d;

	logic [7:0] c;
	logic [3:0] d;
	logic       is_dig;
	logic       is_alp;
	logic       is_spc;
	logic       accept;

	// keyword candidates after one more identifier character
	function automatic logic [stn_pkg::KW_COUNT-1:0] cand_step(
		input logic [LEN_W-1:0]             len,
		input logic [stn_pkg::KW_COUNT-1:0] cand,
		input logic [7:0]                   ch
	);
		logic [stn_pkg::KW_COUNT-1:0] r;
		logic [4:0][7:0]              t;
		r = cand;
		for (int k = 0; k < stn_pkg::KW_COUNT; k++) begin
			t = stn_pkg::kw_text(4'(k));
			if (len >= LEN_W'(stn_pkg::kw_len(4'(k))) || t[len[2:0]] != ch) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	// single-character punctuators: hit bit and code
	function automatic logic [4:0] punct_code(input logic [7:0] ch);
		case (ch)
			";": return {1'b1, 4'd0};
			":": return {1'b1, 4'd1};
			".": return {1'b1, 4'd2};
			"?": return {1'b1, 4'd3};
			",": return {1'b1, 4'd4};
			"(": return {1'b1, 4'd5};
			")": return {1'b1, 4'd6};
			"{": return {1'b1, 4'd7};
			"}": return {1'b1, 4'd8};
			"[": return {1'b1, 4'd9};
			"]": return {1'b1, 4'd10};
			"+": return {1'b1, 4'd11};
			"-": return {1'b1, 4'd12};
			"*": return {1'b1, 4'd13};
			"/": return {1'b1, 4'd14};
			default: return 5'd0;
		endcase
	endfunction

	function automatic stn_pkg::tok_rec_t direct_rec(input logic [5:0] kind);
		stn_pkg::tok_rec_t r;
		r = '0;
		r.cls  = stn_pkg::REC_DIRECT;
		r.kind = kind;
		return r;
	endfunction

	// byte classes
	assign c      = char_in.char_byte;
	assign d      = c[3:0];
	assign is_dig = (c >= "0") && (c <= "9");
	assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_spc = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);

	assign char_in.ready = room;
	assign accept        = char_in.valid && room;

	// decimal digit step: acc * 10 + d
	logic [63:0] acc10;
	logic        dig_skip;
	logic        dig_room;
	logic [1:0]  pm1;

	assign acc10    = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, d};
	assign dig_skip = (acc_q == 64'd0) && (d == 4'd0);
	assign dig_room = dcnt_q < 5'(stn_pkg::MAX_SIG);
	assign pm1      = pcmp_q - 2'd1;

	// token that the pending state gives when it is closed
	stn_pkg::tok_rec_t f_rec;

	always_comb begin
		f_rec = '0;
		case (mode_q)
			MODE_CMP: begin
				f_rec = direct_rec(stn_pkg::TK_ASSIGN + {3'b000, pm1, 1'b0});
			end
			MODE_IDENT: begin
				f_rec.cls  = stn_pkg::REC_IDENT;
				f_rec.ilen = stn_pkg::REC_LEN_W'(ilen_q);
				f_rec.cand = cand_q;
			end
			MODE_INT: begin
				f_rec.cls = stn_pkg::REC_INT;
				f_rec.acc = acc_q;
				f_rec.ovf = ovf_q;
			end
			MODE_FRAC: begin
				f_rec.cls  = stn_pkg::REC_REAL;
				f_rec.acc  = acc_q;
				f_rec.frac = fcnt_q;
				f_rec.ovf  = ovf_q;
			end
			default: ;
		endcase
	end

	// scan of a byte from the cleared state
	logic [4:0]                   pc;
	logic [2:0]                   i_mode;
	logic [63:0]                  i_acc;
	logic [4:0]                   i_dcnt;
	logic [LEN_W-1:0]             i_ilen;
	logic [stn_pkg::KW_COUNT-1:0] i_cand;
	logic [1:0]                   i_pcmp;
	logic                         i_emit;
	stn_pkg::tok_rec_t            i_rec;

	assign pc = punct_code(c);

	always_comb begin
		i_mode = MODE_IDLE;
		i_acc  = '0;
		i_dcnt = '0;
		i_ilen = '0;
		i_cand = ALL_KEYS;
		i_pcmp = 2'd0;
		i_emit = 1'b0;
		i_rec  = direct_rec(stn_pkg::TK_FAIL);
		if (is_spc) begin
			i_emit = 1'b0;
		end else if (pc[4]) begin
			i_emit = 1'b1;
			i_rec  = direct_rec({2'b00, pc[3:0]});
		end else if (c == "=") begin
			i_mode = MODE_CMP;
			i_pcmp = 2'd1;
		end else if (c == "<") begin
			i_mode = MODE_CMP;
			i_pcmp = 2'd2;
		end else if (c == ">") begin
			i_mode = MODE_CMP;
			i_pcmp = 2'd3;
		end else if (is_dig) begin
			i_mode = MODE_INT;
			i_acc  = {60'd0, d};
			i_dcnt = {4'd0, (d != 4'd0)};
		end else if (is_alp) begin
			i_mode = MODE_IDENT;
			i_ilen = LEN_W'(1);
			i_cand = cand_step('0, ALL_KEYS, c);
		end else begin
			i_emit = 1'b1;
		end
	end

	// next state and produced tokens
	logic              f_v;
	logic              s_v;
	logic              take_idle;
	logic              do_clear;
	stn_pkg::tok_rec_t s_rec;

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		dcnt_d    = dcnt_q;
		fcnt_d    = fcnt_q;
		ilen_d    = ilen_q;
		cand_d    = cand_q;
		pcmp_d    = pcmp_q;
		ovf_d     = ovf_q;
		f_v       = 1'b0;
		s_v       = 1'b0;
		s_rec     = direct_rec(stn_pkg::TK_END);
		take_idle = 1'b0;
		do_clear  = 1'b0;
		if (char_in.end_of_input) begin
			f_v      = (mode_q != MODE_IDLE);
			s_v      = 1'b1;
			do_clear = 1'b1;
		end else begin
			case (mode_q)
				MODE_CMP: begin
					if (c == "=") begin
						s_v      = 1'b1;
						s_rec    = direct_rec(stn_pkg::TK_ASSIGN + {3'b000, pm1, 1'b1});
						do_clear = 1'b1;
					end else begin
						f_v       = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_alp || is_dig || c == "_") begin
						cand_d = cand_step(ilen_q, cand_q, c);
						if (ilen_q < LEN_W'(MAX_NAME_LENGTH)) begin
							ilen_d = ilen_q + LEN_W'(1);
						end
					end else begin
						f_v       = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_dig) begin
						if (!dig_skip) begin
							if (dig_room) begin
								acc_d  = acc10;
								dcnt_d = dcnt_q + 5'd1;
							end else begin
								ovf_d = 1'b1;
							end
						end
					end else if (c == ".") begin
						mode_d = MODE_FRAC;
					end else begin
						f_v       = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_dig) begin
						if (!dig_skip) begin
							if (dig_room) begin
								acc_d  = acc10;
								dcnt_d = dcnt_q + 5'd1;
							end else begin
								ovf_d = 1'b1;
							end
						end
						if (fcnt_q < 5'(stn_pkg::MAX_SIG)) begin
							fcnt_d = fcnt_q + 5'd1;
						end else begin
							ovf_d = 1'b1;
						end
					end else if (c == "f") begin
						f_v      = 1'b1;
						do_clear = 1'b1;
					end else begin
						f_v       = 1'b1;
						take_idle = 1'b1;
					end
				end
				default: begin
					take_idle = 1'b1;
				end
			endcase
		end
		if (do_clear) begin
			mode_d = MODE_IDLE;
			acc_d  = '0;
			dcnt_d = '0;
			fcnt_d = '0;
			ilen_d = '0;
			cand_d = ALL_KEYS;
			pcmp_d = 2'd0;
			ovf_d  = 1'b0;
		end
		if (take_idle) begin
			mode_d = i_mode;
			acc_d  = i_acc;
			dcnt_d = i_dcnt;
			fcnt_d = '0;
			ilen_d = i_ilen;
			cand_d = i_cand;
			pcmp_d = i_pcmp;
			ovf_d  = 1'b0;
			s_v    = i_emit;
			s_rec  = i_rec;
		end
	end

	// queue write request, closing token first
	always_comb begin
		push.push0     = accept && (f_v || s_v);
		push.push1     = accept && f_v && s_v;
		push.rec0      = f_v ? f_rec : s_rec;
		push.rec0.last = !(f_v && s_v);
		push.rec1      = s_rec;
		push.rec1.last = 1'b1;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			dcnt_q <= '0;
			fcnt_q <= '0;
			ilen_q <= '0;
			cand_q <= ALL_KEYS;
			pcmp_q <= 2'd0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			dcnt_q <= dcnt_d;
			fcnt_q <= fcnt_d;
			ilen_q <= ilen_d;
			cand_q <= cand_d;
			pcmp_q <= pcmp_d;
			ovf_q  <= ovf_d;
		end
	end

	// a compare operator is pending exactly in compare mode
	a_cmp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_CMP) == (pcmp_q != 2'd0))
		else $error("compare code out of step with scan mode");

	// end of input leaves the scanner idle
	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && char_in.end_of_input |=> mode_q == MODE_IDLE && acc_q == 64'd0)
		else $error("scanner not cleared after end of input");

endmodule

`default_nettype wire

// ----- hw/rtl/stn_queue.sv -----
// ----------------------------------------------------------------------------
// stn_queue: token record queue
// Small register queue between front and back; takes up to two records
// per cycle and gives one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stn_pkg::q_push_t  push,
	input  wire logic              pop,
	output logic                   room,
	output logic                   head_valid,
	output stn_pkg::tok_rec_t      head
);

	localparam int PTR_W = $clog2(stn_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(stn_pkg::QUEUE_DEPTH + 1);

	stn_pkg::tok_rec_t mem_q [stn_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	// room for a full two-record request
	assign room       = cnt_q <= CNT_W'(stn_pkg::QUEUE_DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	// record storage
	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_q] <= push.rec0;
		end
		if (push.push1) begin
			mem_q[PTR_W'(wr_q + 1'b1)] <= push.rec1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PTR_W'(wr_q + PTR_W'(push.push0) + PTR_W'(push.push1));
			if (pop) begin
				rd_q <= PTR_W'(rd_q + 1'b1);
			end
			cnt_q <= CNT_W'(cnt_q + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop));
		end
	end

	// the front writes only after checking for room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> cnt_q <= CNT_W'(stn_pkg::QUEUE_DEPTH - 2))
		else $error("queue written without room");

	// a second record never goes without a first
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second record written alone");

endmodule

`default_nettype wire

// ----- hw/rtl/stn_back.sv -----
// ----------------------------------------------------------------------------
// stn_back: token resolver and output stage
// Resolves keywords, integer range and overflow for the queue head and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stn_back #(
	parameter int MAX_NAME_LENGTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire stn_pkg::tok_rec_t  head,
	output logic                    pop,
	stn_tok_if.source               token_out
);

	localparam int LEN_W = $clog2(MAX_NAME_LENGTH + 1);

	logic [5:0]       r_kind;
	logic [30:0]      r_int;
	logic [63:0]      r_mant;
	logic [4:0]       r_frac;
	logic [LEN_W-1:0] r_len;

	// final kind and value fields of the head record
	always_comb begin
		r_kind = head.kind;
		r_int  = '0;
		r_mant = '0;
		r_frac = '0;
		r_len  = '0;
		case (head.cls)
			stn_pkg::REC_IDENT: begin
				r_kind = stn_pkg::TK_IDENT;
				r_len  = LEN_W'(head.ilen);
				for (int k = stn_pkg::KW_COUNT - 1; k >= 0; k--) begin
					if (head.cand[k] &&
						head.ilen == stn_pkg::REC_LEN_W'(stn_pkg::kw_len(4'(k)))) begin
						r_kind = stn_pkg::TK_KEY0 + 6'(k);
						r_len  = '0;
					end
				end
			end
			stn_pkg::REC_INT: begin
				if (head.ovf || head.acc[63:31] != '0) begin
					r_kind = stn_pkg::TK_FAIL;
				end else begin
					r_kind = stn_pkg::TK_INT;
					r_int  = head.acc[30:0];
				end
			end
			stn_pkg::REC_REAL: begin
				if (head.ovf) begin
					r_kind = stn_pkg::TK_FAIL;
				end else begin
					r_kind = stn_pkg::TK_REAL;
					r_mant = head.acc;
					r_frac = head.frac;
				end
			end
			default: ;
		endcase
	end

	logic             valid_q;
	logic [5:0]       kind_q;
	logic [30:0]      int_q;
	logic [63:0]      mant_q;
	logic [4:0]       frac_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;

	assign pop = head_valid && (!valid_q || token_out.ready);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (token_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= r_kind;
			int_q  <= r_int;
			mant_q <= r_mant;
			frac_q <= r_frac;
			len_q  <= r_len;
			last_q <= head.last;
		end
	end

	assign token_out.valid           = valid_q;
	assign token_out.token_kind      = kind_q;
	assign token_out.int_value       = int_q;
	assign token_out.real_mantissa   = mant_q;
	assign token_out.fraction_digits = frac_q;
	assign token_out.name_length     = len_q;
	assign token_out.last_of_run     = last_q;

	// the end token always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == stn_pkg::TK_END |-> last_q)
		else $error("end token without last_of_run");

endmodule

`default_nettype wire

// ----- sim/source_text_tokenizer_checker.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker: token prediction and comparison
// Watches both channels, predicts the tokens of every accepted character
// request and compares each accepted token field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer_checker (
	input  logic clk,
	input  logic arst_n,
	stn_char_if  chars,
	stn_tok_if   tokens,
	output int   fail_count,
	output int   outstanding,
	output int   tokens_seen
);

	localparam int NAME_LIMIT = 64;

	typedef enum logic [2:0] {SCAN_IDLE, SCAN_CMP, SCAN_IDENT, SCAN_INT, SCAN_FRAC} scan_t;
	typedef enum logic [1:0] {CMP_NONE, CMP_EQ, CMP_LT, CMP_GT} cmp_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [30:0] ival;
		logic [63:0] mant;
		logic [4:0]  frac;
		logic [6:0]  nlen;
		logic        last;
	} token_t;

	string punct_chars = ";:.?,(){}[]+-*/";
	string kw_words [stn_pkg::KW_COUNT] = '{"in", "out", "event", "node", "query", "float",
		"bool", "true", "false"};

	// scanner state of the prediction
	scan_t                         mode = SCAN_IDLE;
	logic [63:0]                   acc = '0;
	int                            sig_digits = 0;
	int                            frac_digits = 0;
	int                            name_len = 0;
	logic [stn_pkg::KW_COUNT-1:0]  kw_live = '1;
	cmp_t                          pend = CMP_NONE;
	logic                          too_long = 1'b0;

	token_t step_toks[$];
	token_t expected_tokens[$];
	int     mismatches = 0;
	int     checked = 0;
	int     waiting = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting;
	assign tokens_seen = checked;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at token %0d: %s is %0h, expected %0h", checked, what, got, want);
		mismatches++;
	endtask

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void push_token(input logic [5:0] kind, input logic [30:0] ival,
		input logic [63:0] mant, input logic [4:0] frac, input logic [6:0] nlen);
		step_toks.push_back('{kind, ival, mant, frac, nlen, 1'b0});
	endfunction

	function automatic void clear_scan();
		mode = SCAN_IDLE;
		acc = '0;
		sig_digits = 0;
		frac_digits = 0;
		name_len = 0;
		kw_live = '1;
		pend = CMP_NONE;
		too_long = 1'b0;
	endfunction

	// = < > alone, or followed by =
	function automatic logic [5:0] compare_kind(input logic with_eq);
		return stn_pkg::TK_ASSIGN + 6'(2 * (int'(pend) - 1)) + 6'(with_eq);
	endfunction

	// leading zeros are dropped, digits past the limit mark overflow
	function automatic void add_digit(input logic [7:0] c);
		int d;
		d = int'(c) - int'("0");
		if (acc == 0 && d == 0)
			return;
		if (sig_digits < stn_pkg::MAX_SIG) begin
			acc = acc * 10 + 64'(d);
			sig_digits++;
		end else begin
			too_long = 1'b1;
		end
	endfunction

	// narrow the keyword candidates with each name character
	function automatic void add_name_char(input logic [7:0] c);
		for (int k = 0; k < stn_pkg::KW_COUNT; k++) begin
			if (name_len >= kw_words[k].len() || kw_words[k][name_len] != c)
				kw_live[k] = 1'b0;
		end
		if (name_len < NAME_LIMIT)
			name_len++;
	endfunction

	// emit the token in progress, if any
	function automatic void flush_pending();
		bit found;
		found = 1'b0;
		case (mode)
			SCAN_CMP: push_token(compare_kind(1'b0), '0, '0, '0, '0);
			SCAN_IDENT: begin
				for (int k = 0; k < stn_pkg::KW_COUNT; k++) begin
					if (!found && kw_live[k] && name_len == kw_words[k].len()) begin
						push_token(stn_pkg::TK_KEY0 + 6'(k), '0, '0, '0, '0);
						found = 1'b1;
					end
				end
				if (!found)
					push_token(stn_pkg::TK_IDENT, '0, '0, '0, 7'(name_len));
			end
			SCAN_INT: begin
				if (too_long || acc > 64'h7FFF_FFFF)
					push_token(stn_pkg::TK_FAIL, '0, '0, '0, '0);
				else
					push_token(stn_pkg::TK_INT, acc[30:0], '0, '0, '0);
			end
			SCAN_FRAC: begin
				if (too_long)
					push_token(stn_pkg::TK_FAIL, '0, '0, '0, '0);
				else
					push_token(stn_pkg::TK_REAL, '0, acc, 5'(frac_digits), '0);
			end
			default: ;
		endcase
		clear_scan();
	endfunction

	// first character of a new token
	function automatic void start_token(input logic [7:0] c);
		bit hit;
		hit = 1'b0;
		clear_scan();
		if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D)
			return;
		for (int k = 0; k < 15; k++) begin
			if (!hit && punct_chars[k] == c) begin
				push_token(6'(k), '0, '0, '0, '0);
				hit = 1'b1;
			end
		end
		if (hit)
			return;
		if (c == "=" || c == "<" || c == ">") begin
			mode = SCAN_CMP;
			pend = (c == "=") ? CMP_EQ : (c == "<") ? CMP_LT : CMP_GT;
		end else if (is_digit(c)) begin
			mode = SCAN_INT;
			add_digit(c);
		end else if (is_alpha(c)) begin
			mode = SCAN_IDENT;
			add_name_char(c);
		end else begin
			push_token(stn_pkg::TK_FAIL, '0, '0, '0, '0);
		end
	endfunction

	// tokens caused by one character request
	function automatic void predict_item(input logic [7:0] c, input logic eoi);
		token_t t;
		step_toks.delete();
		if (eoi) begin
			flush_pending();
			push_token(stn_pkg::TK_END, '0, '0, '0, '0);
		end else begin
			case (mode)
				SCAN_CMP: begin
					if (c == "=") begin
						push_token(compare_kind(1'b1), '0, '0, '0, '0);
						clear_scan();
					end else begin
						flush_pending();
						start_token(c);
					end
				end
				SCAN_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						add_name_char(c);
					end else begin
						flush_pending();
						start_token(c);
					end
				end
				SCAN_INT: begin
					if (is_digit(c)) begin
						add_digit(c);
					end else if (c == ".") begin
						mode = SCAN_FRAC;
					end else begin
						flush_pending();
						start_token(c);
					end
				end
				SCAN_FRAC: begin
					if (is_digit(c)) begin
						add_digit(c);
						if (frac_digits < stn_pkg::MAX_SIG)
							frac_digits++;
						else
							too_long = 1'b1;
					end else if (c == "f") begin
						flush_pending();
					end else begin
						flush_pending();
						start_token(c);
					end
				end
				default: start_token(c);
			endcase
		end
		foreach (step_toks[i]) begin
			t = step_toks[i];
			t.last = (i == step_toks.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// compare one accepted token with the oldest prediction
	task automatic compare_token();
		token_t want;
		checked++;
		if (expected_tokens.size() == 0) begin
			report_mismatch("unexpected token, kind", 64'(tokens.token_kind), '0);
			return;
		end
		want = expected_tokens.pop_front();
		if (tokens.token_kind !== want.kind)
			report_mismatch("token_kind", 64'(tokens.token_kind), 64'(want.kind));
		if (tokens.int_value !== want.ival)
			report_mismatch("int_value", 64'(tokens.int_value), 64'(want.ival));
		if (tokens.real_mantissa !== want.mant)
			report_mismatch("real_mantissa", tokens.real_mantissa, want.mant);
		if (tokens.fraction_digits !== want.frac)
			report_mismatch("fraction_digits", 64'(tokens.fraction_digits), 64'(want.frac));
		if (tokens.name_length !== want.nlen)
			report_mismatch("name_length", 64'(tokens.name_length), 64'(want.nlen));
		if (tokens.last_of_run !== want.last)
			report_mismatch("last_of_run", 64'(tokens.last_of_run), 64'(want.last));
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			waiting = 0;
		end else begin
			if (tokens.valid && tokens.ready)
				compare_token();
			if (chars.valid && chars.ready)
				predict_item(chars.char_byte, chars.end_of_input);
			waiting = expected_tokens.size();
		end
	end

endmodule

// ----- sim/tb_source_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_top: testbench of the source text tokenizer
// Feeds a directed character sequence and then random, mostly well-formed
// source text under three mixes of sender and receiver idling, with one long
// receiver stall; a checker module predicts and compares every token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_source_text_tokenizer_top;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       tx_valid = 1'b0;
	logic [7:0] tx_byte = '0;
	logic       tx_end = 1'b0;
	logic       rx_ready = 1'b0;

	int fail_count;
	int outstanding;
	int tokens_seen;
	int items_accepted = 0;
	int tx_idle_pct = 32;
	int rx_idle_pct = 63;
	int hold_left = 0;
	int cycles = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;

	logic [7:0] lexeme[$];
	string kw_words [9] = '{"in", "out", "event", "node", "query", "float", "bool", "true",
		"false"};
	string compare_ops [6] = '{"=", "==", "<", "<=", ">", ">="};
	string punct_chars = ";:.?,(){}[]+-*/";
	logic [7:0] space_chars [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

	stn_char_if char_bus ();
	stn_tok_if #(.LEN_W(7)) tok_bus ();

	assign char_bus.valid        = tx_valid;
	assign char_bus.char_byte    = tx_byte;
	assign char_bus.end_of_input = tx_end;
	assign tok_bus.ready         = rx_ready;

	source_text_tokenizer_top #(
		.MAX_NAME_LENGTH(64)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_bus),
		.token_out (tok_bus)
	);

	source_text_tokenizer_checker token_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (char_bus),
		.tokens      (tok_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.tokens_seen (tokens_seen)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rx_ready <= 1'b0;
			hold_left--;
		end else if (hold_armed && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rx_ready <= 1'b0;
		end else begin
			rx_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one character request, returns at the accepting edge
	task automatic send_item(input logic [7:0] b, input logic eoi);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			tx_valid <= 1'b0;
			@(negedge clk);
		end
		tx_valid <= 1'b1;
		tx_byte  <= b;
		tx_end   <= eoi;
		do @(posedge clk); while (char_bus.ready !== 1'b1);
		items_accepted++;
	endtask

	// stop sending until every predicted token has come out
	task automatic drain();
		@(negedge clk);
		tx_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] digit_char(input int lowest);
		return 8'(int'("0") + $urandom_range(9, lowest));
	endfunction

	function automatic logic [7:0] name_char(input bit first);
		int r;
		r = first ? $urandom_range(51) : $urandom_range(62);
		if (r < 26)
			return 8'(int'("a") + r);
		if (r < 52)
			return 8'(int'("A") + r - 26);
		if (r < 62)
			return 8'(int'("0") + r - 52);
		return "_";
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			lexeme.push_back(s[i]);
	endfunction

	function automatic void push_digits(input int n, input bit nonzero_first);
		for (int i = 0; i < n; i++)
			lexeme.push_back(digit_char((i == 0 && nonzero_first) ? 1 : 0));
	endfunction

	// one random token of source text, an end request, or a noise byte
	task automatic send_lexeme();
		int    sel;
		int    r;
		int    n;
		string w;
		lexeme.delete();
		sel = $urandom_range(99);
		r = $urandom_range(99);
		if (sel < 30) begin
			// names and keywords, near misses, long names
			w = kw_words[$urandom_range(8)];
			if (r < 40) begin
				push_text(w);
			end else if (r < 50) begin
				push_text(w);
				lexeme.push_back(name_char(1'b0));
			end else if (r < 60) begin
				push_text(w.substr(0, w.len() - 2));
			end else begin
				n = (r < 95) ? $urandom_range(10, 1) : $urandom_range(70, 60);
				lexeme.push_back(name_char(1'b1));
				repeat (n - 1) lexeme.push_back(name_char(1'b0));
			end
		end else if (sel < 50) begin
			// integers around the 31-bit limit and over-long ones
			if (r < 5)
				push_text("2147483647");
			else if (r < 10)
				push_text("2147483648");
			else if (r < 18)
				push_digits($urandom_range(23, 20), 1'b1);
			else if (r < 28) begin
				push_text("00");
				push_digits($urandom_range(4, 1), 1'b0);
			end else
				push_digits($urandom_range(10, 1), 1'b0);
		end else if (sel < 65) begin
			// reals, with and without suffix
			if (r < 5) begin
				push_text("9999999999.999999999");
			end else begin
				push_digits($urandom_range(6, 1), 1'b0);
				push_text(".");
				push_digits((r < 13) ? $urandom_range(21, 18) : $urandom_range(8, 0), 1'b0);
			end
			if ($urandom_range(99) < 30)
				push_text("f");
		end else if (sel < 80) begin
			lexeme.push_back(punct_chars[$urandom_range(14)]);
		end else if (sel < 90) begin
			push_text(compare_ops[$urandom_range(5)]);
		end else if (sel < 95) begin
			lexeme.push_back(8'($urandom_range(255)));
		end else begin
			send_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		// half the tokens run straight into the next one
		if ($urandom_range(1))
			lexeme.push_back(space_chars[$urandom_range(3)]);
		foreach (lexeme[i])
			send_item(lexeme[i], 1'b0);
	endtask

	// stimulus
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: keyword, the =, <= and >= compare forms, leading zeros, suffix,
		// empty fraction, unknown bytes, name with underscore, repeated end
		lexeme.delete();
		push_text("in=<=>==0012.5f3._x_9");
		foreach (lexeme[i])
			send_item(lexeme[i], 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b1);
		send_item(8'h7F, 1'b1);
		drain();

		// sender idles less than receiver
		while (items_accepted < 525)
			send_lexeme();
		drain();
		@(posedge clk);
		tx_idle_pct = 63;
		rx_idle_pct = 32;

		// receiver idles less than sender
		while (items_accepted < 1025)
			send_lexeme();
		drain();
		@(posedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;

		// full rate, with one long receiver hold-off
		while (items_accepted < 1525) begin
			send_lexeme();
			if (items_accepted >= 1125)
				hold_armed = 1'b1;
		end
		drain();
		repeat (10) @(negedge clk);

		$display("run covered %0d character requests over three idle mixes and a long stall",
			items_accepted);
		$display("%0d tokens compared, %0d mismatches", tokens_seen, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/stn_pkg.sv
hw/rtl/stn_char_if.sv
hw/rtl/stn_tok_if.sv
hw/rtl/stn_front.sv
hw/rtl/stn_queue.sv
hw/rtl/stn_back.sv
hw/rtl/source_text_tokenizer_top.sv
sim/source_text_tokenizer_checker.sv
sim/tb_source_text_tokenizer_top.sv
